[hdl/cmlog_pkg.sv]
// Package for the count-min-log sketch: sizes, register indexes and sequencer states.
`default_nettype none

package cmlog_pkg;

  // Default geometry
  localparam int ROWS_DEF        = 4;
  localparam int ROW_ENTRIES_DEF = 1024;

  // Field widths
  localparam int KEY_W      = 64;
  localparam int HALF_W     = 32;
  localparam int CTR_W      = 4;
  localparam int EST_W      = 15;
  localparam int TOTAL_W    = 64;
  localparam int OFFSET_W   = 54;
  localparam int MASK_W     = 16;
  localparam int HASH_REGS  = 4;
  localparam int REG_SEL_W  = 2;

  localparam logic [CTR_W-1:0] CTR_MAX = 4'd15;

  // Stream word layouts
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MULT_ROW0   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ROW0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END         = 4'd8;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Item sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_READ,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

[hdl/count_min_log_sketch.sv]
// Count-min-log sketch with conservative update: one counter bank per row.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_tvalid / in_tready  | tdata: key; tuser: command
//  out_    | output    | out_tvalid / out_tready| tdata: min, estimate, total; tuser: incremented
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An accepted item runs through the sequencer before the next one is taken: three steps on each row's
// 32x32 multiplier build the 64-bit hash, a read step reads the row banks, and a write step compares,
// writes back and loads the output register.
// After reset a clearing pass zeroes the banks, with in_tready low.
// A result waiting on out_tready holds the write-back step; the next word is taken after it.
`default_nettype none

module count_min_log_sketch #(
  parameter int ROWS        = cmlog_pkg::ROWS_DEF,
  parameter int ROW_ENTRIES = cmlog_pkg::ROW_ENTRIES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [cmlog_pkg::IN_TDATA_W-1:0]   in_tdata,   // [63:0] key
  input  wire  [0:0]                         in_tuser,   // [0] command
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [cmlog_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [3:0] min_log_count,
                                                         // [18:4] estimate,
                                                         // [82:19] total_updates, rest 0
  output logic [0:0]                         out_tuser,  // [0] incremented
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [cmlog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [cmlog_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ColW = (ROW_ENTRIES > 2) ? $clog2(ROW_ENTRIES) : 1;
  localparam int KW   = cmlog_pkg::KEY_W;
  localparam int HW   = cmlog_pkg::HALF_W;
  localparam int CW   = cmlog_pkg::CTR_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [KW-1:0]                  mult_r   [cmlog_pkg::HASH_REGS];
  logic [cmlog_pkg::OFFSET_W-1:0] offset_r [cmlog_pkg::HASH_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cmlog_pkg::HASH_REGS; i++) begin
        mult_r[i]   <= KW'(1);
        offset_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < cmlog_pkg::REG_OFFSET_ROW0) begin
        mult_r[cfg_index[cmlog_pkg::REG_SEL_W-1:0]] <= cfg_data;
      end else if (cfg_index < cmlog_pkg::REG_END) begin
        offset_r[cfg_index[cmlog_pkg::REG_SEL_W-1:0]] <= cfg_data[cmlog_pkg::OFFSET_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  cmlog_pkg::state_t state_r, state_nxt;
  logic [ColW-1:0]   clr_cnt_r;
  logic              clr_last;
  logic              slot_free;
  logic              out_valid_r;

  // control outputs of the sequencer
  logic              accept;
  logic              clr_en;
  logic              step0, step1, step2;
  logic              rd_en;
  logic              commit;

  assign clr_last  = (clr_cnt_r == ColW'(ROW_ENTRIES - 1));
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmlog_pkg::ST_CLEAR: if (clr_last) state_nxt = cmlog_pkg::ST_IDLE;
      cmlog_pkg::ST_IDLE:  if (in_tvalid) state_nxt = cmlog_pkg::ST_MUL0;
      cmlog_pkg::ST_MUL0:  state_nxt = cmlog_pkg::ST_MUL1;
      cmlog_pkg::ST_MUL1:  state_nxt = cmlog_pkg::ST_MUL2;
      cmlog_pkg::ST_MUL2:  state_nxt = cmlog_pkg::ST_READ;
      cmlog_pkg::ST_READ:  state_nxt = cmlog_pkg::ST_WRITE;
      cmlog_pkg::ST_WRITE: if (slot_free) state_nxt = cmlog_pkg::ST_IDLE;
      default:             state_nxt = cmlog_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    clr_en    = 1'b0;
    step0     = 1'b0;
    step1     = 1'b0;
    step2     = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    case (state_r)
      cmlog_pkg::ST_CLEAR: clr_en    = 1'b1;
      cmlog_pkg::ST_IDLE:  in_tready = 1'b1;
      cmlog_pkg::ST_MUL0:  step0     = 1'b1;
      cmlog_pkg::ST_MUL1:  step1     = 1'b1;
      cmlog_pkg::ST_MUL2:  step2     = 1'b1;
      cmlog_pkg::ST_READ:  rd_en     = 1'b1;
      cmlog_pkg::ST_WRITE: commit    = slot_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cmlog_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_en) clr_cnt_r <= clr_cnt_r + ColW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Captured item
  logic [KW-1:0] key_r;
  logic          cmd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_tdata[KW-1:0];
      cmd_r <= in_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-row hash, column and counter bank
  logic [ColW-1:0] col     [ROWS];
  logic [CW-1:0]   rd_data_r [ROWS];
  logic [ROWS-1:0] row_hit;

  logic [CW-1:0]   minc;
  logic            do_inc;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [HW-1:0]   mul_a, mul_b;
    logic [KW-1:0]   prod;
    logic [KW-1:0]   acc_r;
    logic [ColW-1:0] col_raw;
    logic [CW-1:0]   bank [ROW_ENTRIES];
    logic            wr_en;
    logic [ColW-1:0] wr_addr;
    logic [CW-1:0]   wr_data;

    // multiplier operand select: low*low, high*low, low*high
    always_comb begin
      mul_a = key_r[HW-1:0];
      mul_b = mult_r[r][HW-1:0];
      if (step1) mul_a = key_r[KW-1:HW];
      if (step2) mul_b = mult_r[r][KW-1:HW];
    end

    assign prod = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};

    // hash accumulator, mod 2^64
    always_ff @(posedge clk) begin
      if (step0) begin
        acc_r <= prod + {{(KW-cmlog_pkg::OFFSET_W){1'b0}}, offset_r[r]};
      end else if (step1 || step2) begin
        acc_r[KW-1:HW] <= acc_r[KW-1:HW] + prod[HW-1:0];
      end
    end

    // top bits, wrapped once past the row end
    assign col_raw = acc_r[KW-1 -: ColW];
    always_comb begin
      col[r] = col_raw;
      if ({1'b0, col_raw} >= (ColW+1)'(ROW_ENTRIES)) col[r] = col_raw - ColW'(ROW_ENTRIES);
    end

    assign row_hit[r] = (rd_data_r[r] == minc) && (rd_data_r[r] != cmlog_pkg::CTR_MAX);
    assign wr_en      = clr_en || (commit && do_inc && row_hit[r]);
    assign wr_addr    = clr_en ? clr_cnt_r : col[r];
    assign wr_data    = clr_en ? '0 : (rd_data_r[r] + CW'(1));

    // counter bank, registered read
    always_ff @(posedge clk) begin
      if (wr_en) bank[wr_addr] <= wr_data;
      if (rd_en) rd_data_r[r] <= bank[col[r]];
    end
  end

  // ---------------------------------------------------------------------------
  // Minimum, increment decision and total
  localparam int TOTAL_W_L = cmlog_pkg::TOTAL_W;
  logic [TOTAL_W_L-1:0]         total_r;
  logic [cmlog_pkg::MASK_W-1:0] pow_mask;
  logic [TOTAL_W_L-1:0]         total_nxt;
  logic                         is_update;

  always_comb begin
    minc = cmlog_pkg::CTR_MAX;
    for (int i = 0; i < ROWS; i++) begin
      if (rd_data_r[i] < minc) minc = rd_data_r[i];
    end
  end

  assign is_update = (cmd_r == cmlog_pkg::CMD_UPDATE);
  assign pow_mask  = (cmlog_pkg::MASK_W'(1) << minc) - cmlog_pkg::MASK_W'(1);
  assign do_inc    = is_update && ((total_r[cmlog_pkg::MASK_W-1:0] & pow_mask) == '0);
  assign total_nxt = total_r + TOTAL_W_L'(is_update);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (commit) begin
      total_r <= total_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic [CW-1:0]              res_min_r;
  logic [cmlog_pkg::EST_W-1:0] res_est_r;
  logic                        res_inc_r;
  logic [TOTAL_W_L-1:0]        res_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_min_r   <= minc;
      res_est_r   <= pow_mask[cmlog_pkg::EST_W-1:0];
      res_inc_r   <= do_inc && (row_hit != '0);
      res_total_r <= total_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cmlog_pkg::OUT_TDATA_W - CW - cmlog_pkg::EST_W - TOTAL_W_L){1'b0}},
                       res_total_r, res_est_r, res_min_r};
  assign out_tuser  = res_inc_r;

endmodule

`default_nettype wire
